### hdl/aas_pkg.sv
package aas_pkg;
  localparam int MaxItems = 16;
  localparam int MaxBidders = 16;
  localparam int CostWidth = 32;
  localparam int PriceWidth = 40;
  localparam int ItemBits = $clog2(MaxItems);
  localparam int BidBits = $clog2(MaxBidders);
  localparam int ValWidth = PriceWidth + 2;
  localparam int IncWidth = 21;
  localparam int IterWidth = 20;
  localparam int CntWidth = 5;

  localparam logic [1:0] RegBidInc = 2'd0;
  localparam logic [1:0] RegMaxIter = 2'd1;
  localparam logic [1:0] RegItems = 2'd2;
  localparam logic [1:0] RegBidders = 2'd3;

  localparam logic OpLoad = 1'b0;
  localparam logic OpSolve = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_POP, ST_SCAN, ST_UPDATE, ST_REPORT
  } state_t;

  typedef logic signed [ValWidth-1:0] val_t;
  typedef logic [PriceWidth-1:0] price_t;

  // one beat flowing down the chain of cells
  typedef struct packed {
    logic valid;
    logic [ItemBits-1:0] idx;
    logic first;
    val_t best;
    logic [ItemBits-1:0] best_i;
    val_t second;
    logic have_second;
  } scan_t;
endpackage

### hdl/aas_cell.sv
module aas_cell (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic upd,
  input  aas_pkg::price_t upd_price,
  input  logic [aas_pkg::ItemBits-1:0] my_index,
  input  logic signed [aas_pkg::CostWidth-1:0] cost,
  input  aas_pkg::scan_t scan_in,
  output aas_pkg::scan_t scan_out,
  output aas_pkg::price_t price
);
  import aas_pkg::*;

  val_t val;
  scan_t nxt;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      price <= '0;
    end else if (upd) begin
      price <= upd_price;
    end
  end

  always_comb begin
    val = ValWidth'(cost) - val_t'({2'b00, price});
    nxt = scan_in;
    if (scan_in.valid && scan_in.idx == my_index) begin
      if (scan_in.first) begin
        nxt.best = val;
        nxt.best_i = my_index;
        nxt.first = 1'b0;
      end else if (val > scan_in.best) begin
        nxt.second = scan_in.best;
        nxt.have_second = 1'b1;
        nxt.best = val;
        nxt.best_i = my_index;
      end else if (!scan_in.have_second || val > scan_in.second) begin
        nxt.second = val;
        nxt.have_second = 1'b1;
      end
    end
  end

  // pass the running best along; each cell acts only on its own beat
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= nxt.valid;
    end
    scan_out.idx <= nxt.idx;
    scan_out.first <= nxt.first;
    scan_out.best <= nxt.best;
    scan_out.best_i <= nxt.best_i;
    scan_out.second <= nxt.second;
    scan_out.have_second <= nxt.have_second;
  end
endmodule

### hdl/auction_assignment_solver.sv
// Load beat: accepted back to back into the cost memory while the solver is idle.
// Solve beat: every bidding round is a pop, a scan as the bid walks all 16 item cells with one
// memory read per cell, and an update, whatever items_used holds.
// The first result beat follows the last bidding round, then one result beat per bidder in use;
// input stalls until the last result leaves.
// Reset (rst, synchronous) restores register defaults and clears prices and FIFO;
// the cost memory holds garbage until written.
module auction_assignment_solver (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic opcode,
  input  logic [3:0] item_index,
  input  logic [3:0] bidder_index,
  input  logic signed [31:0] cost_value,
  output logic out_valid,
  input  logic out_stall,
  output logic [3:0] bidder,
  output logic signed [4:0] assigned_item,
  output logic stopped_early,
  output logic last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import aas_pkg::*;

  logic [IncWidth-1:0] bid_increment;
  logic [IterWidth-1:0] max_iterations;
  logic [CntWidth-1:0] items_used, bidders_used;
  logic [ItemBits:0] ni;
  logic [BidBits:0] nb;

  logic signed [CostWidth-1:0] cost_mem [MaxItems*MaxBidders];
  logic signed [CostWidth-1:0] cost_rd;

  state_t state, state_next;
  logic [BidBits-1:0] fifo [MaxBidders];
  logic [BidBits-1:0] fifo_head;
  logic [BidBits:0] fifo_count;
  logic [IterWidth-1:0] round_count;
  logic [BidBits-1:0] who;
  logic [ItemBits:0] step;
  logic [BidBits:0] rep;
  logic early;
  logic owner_v [MaxBidders];
  logic [ItemBits-1:0] owner [MaxBidders];

  scan_t chain [MaxItems+1];
  scan_t res;
  price_t prices [MaxItems];
  logic cell_upd [MaxItems];
  price_t new_price;
  logic clear;
  logic [ItemBits:0] wait_cnt;

  logic in_acc, out_acc;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cfg_ready = (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    ni = items_used[ItemBits:0];
    if (items_used == '0) ni = (ItemBits+1)'(1);
    if (items_used > CntWidth'(MaxItems)) ni = (ItemBits+1)'(MaxItems);
    nb = bidders_used[BidBits:0];
    if (bidders_used == '0) nb = (BidBits+1)'(1);
    if (bidders_used > CntWidth'(MaxBidders)) nb = (BidBits+1)'(MaxBidders);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bid_increment <= IncWidth'(66);
      max_iterations <= IterWidth'(1000);
      items_used <= CntWidth'(16);
      bidders_used <= CntWidth'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegBidInc: bid_increment <= cfg_data[IncWidth-1:0];
        RegMaxIter: max_iterations <= cfg_data[IterWidth-1:0];
        RegItems: items_used <= cfg_data[CntWidth-1:0];
        RegBidders: bidders_used <= cfg_data[CntWidth-1:0];
        default: ;
      endcase
    end
  end

  // cost memory, one read per cycle for the cell on turn
  logic [ItemBits-1:0] rd_item;
  assign rd_item = step[ItemBits-1:0];
  always_ff @(posedge clk) begin
    if (in_acc && opcode == OpLoad)
      cost_mem[{item_index, bidder_index}] <= cost_value;
    cost_rd <= cost_mem[{rd_item, who}];
  end

  // injection: beat enters cell 0 in the cycle after the memory read is issued;
  // cell k sees the beat at step k+1 with the cost read for item k, and idx==k if item k is in use
  scan_t inj;
  always_comb begin
    inj = '0;
    inj.valid = (state == ST_SCAN) && (step == '0);
    inj.first = 1'b1;
  end

  // the beat is carried by a token: cell k acts when step reaches k+1;
  // cells past the items in use get a foreign idx and pass the beat untouched
  genvar g;
  generate
    for (g = 0; g < MaxItems; g++) begin : g_cell
      scan_t cin;
      always_comb begin
        cin = chain[g];
        if ((ItemBits+1)'(g) < ni) cin.idx = ItemBits'(g);
        else cin.idx = ItemBits'(g + 1);
      end
      aas_cell u_cell (
        .clk(clk), .rst(rst), .clear(clear),
        .upd(cell_upd[g]), .upd_price(new_price),
        .my_index(ItemBits'(g)), .cost(cost_rd),
        .scan_in(cin), .scan_out(chain[g+1]), .price(prices[g])
      );
      assign cell_upd[g] = (state == ST_UPDATE) && res.best_i == ItemBits'(g);
    end
  endgenerate

  // hold the beat at cell 0 until memory data aligns: feed the token through the inj_d register
  scan_t inj_d;
  always_ff @(posedge clk) begin
    if (rst) inj_d <= '0;
    else inj_d <= inj;
  end
  assign chain[0] = inj_d;

  // cost_rd holds item k in the cycle the beat sits at cell k: the read for
  // item k is issued at step k and the beat reaches cell k at step k+1
  always_ff @(posedge clk) begin
    if (chain[MaxItems].valid) res <= chain[MaxItems];
    else if (state == ST_POP) res.valid <= 1'b0;
  end

  // increment and saturating price
  logic [ValWidth:0] inc;
  logic [ValWidth+1:0] np;
  always_comb begin
    inc = (ValWidth+1)'(bid_increment);
    if (res.have_second)
      inc = inc + (ValWidth+1)'(res.best - res.second);
    np = (ValWidth+2)'(prices[res.best_i]) + (ValWidth+2)'(inc);
    if (np > (ValWidth+2)'({PriceWidth{1'b1}}))
      new_price = {PriceWidth{1'b1}};
    else
      new_price = np[PriceWidth-1:0];
  end

  logic evict;
  logic [BidBits-1:0] evicted;
  always_comb begin
    evict = 1'b0;
    evicted = '0;
    for (int b = MaxBidders-1; b >= 0; b--) begin
      if (owner_v[b] && owner[b] == res.best_i && (BidBits+1)'(b) < nb) begin
        evict = 1'b1;
        evicted = BidBits'(b);
      end
    end
  end

  always_comb begin
    state_next = state;
    clear = 1'b0;
    case (state)
      ST_IDLE: if (in_acc && opcode == OpSolve) begin
        state_next = ST_POP;
        clear = 1'b1;
      end
      ST_POP: begin
        if (fifo_count == '0 || round_count >= max_iterations) state_next = ST_REPORT;
        else state_next = ST_SCAN;
      end
      ST_SCAN: if (wait_cnt == '0 && res.valid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_POP;
      ST_REPORT: if (out_acc && last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // step drives the memory address; beat enters at step 0 via inj then inj_d
  assign wait_cnt = '0;
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head <= '0;
      fifo_count <= '0;
      round_count <= '0;
      step <= '0;
      rep <= '0;
      early <= 1'b0;
      for (int b = 0; b < MaxBidders; b++) owner_v[b] <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (clear) begin
          fifo_head <= '0;
          fifo_count <= nb;
          round_count <= '0;
          rep <= '0;
          for (int b = 0; b < MaxBidders; b++) begin
            owner_v[b] <= 1'b0;
            fifo[b] <= BidBits'(b);
          end
        end
        ST_POP: begin
          who <= fifo[fifo_head];
          step <= '0;
          early <= fifo_count != '0;
          if (!(fifo_count == '0 || round_count >= max_iterations)) begin
            fifo_head <= fifo_head + 1'b1;
            fifo_count <= fifo_count - 1'b1;
          end
        end
        ST_SCAN: if (step <= (ItemBits+1)'(MaxItems)) step <= step + 1'b1;
        ST_UPDATE: begin
          if (evict) begin
            owner_v[evicted] <= 1'b0;
            fifo[BidBits'(fifo_head + fifo_count[BidBits-1:0])] <= evicted;
            fifo_count <= fifo_count + 1'b1;
          end
          owner_v[who] <= 1'b1;
          owner[who] <= res.best_i;
          round_count <= round_count + 1'b1;
        end
        ST_REPORT: if (out_acc) rep <= rep + 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid = (state == ST_REPORT);
  assign bidder = rep[BidBits-1:0];
  assign assigned_item = owner_v[rep[BidBits-1:0]] ?
                         {1'b0, owner[rep[BidBits-1:0]]} : 5'sb11111;
  assign stopped_early = early;
  assign last = (rep + 1'b1) == nb;

  a_report_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rep < nb) else $error("report past last bidder");
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= (BidBits+1)'(MaxBidders)) else $error("fifo overflow");
  a_update_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |=> state == ST_POP) else $error("update did not return");
endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import aas_pkg::*;

  localparam longint PriceMax = (64'd1 << PriceWidth) - 1;

  typedef struct {
    logic [3:0] bidder;
    logic [4:0] item;
    logic       early;
    logic       last;
  } assign_beat_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic [3:0] item_index;
  logic [3:0] bidder_index;
  logic signed [31:0] cost_value;
  logic out_valid;
  logic out_stall;
  logic [3:0] bidder;
  logic signed [4:0] assigned_item;
  logic stopped_early;
  logic last;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  auction_assignment_solver u_top (.*);

  // shadow state of the solver
  longint cost_mem [MaxItems][MaxBidders];
  bit     loaded [MaxItems][MaxBidders];
  logic [20:0] eps_reg;
  logic [19:0] iter_reg;
  logic [4:0]  items_reg;
  logic [4:0]  bidders_reg;

  assign_beat_t expected_assign[$];
  int errors;
  int items_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;
  bit hold_arm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int clamp_cnt(logic [4:0] v);
    if (v < 1) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  // forward auction over the shadow cost store, queue one beat per bidder
  function automatic void predict_assignment();
    int ni, nb, who, best_i, rounds;
    longint price [MaxItems];
    int owner [MaxBidders];
    int waiting[$];
    longint best, second, val, inc, np;
    bit have_second;
    assign_beat_t beat;
    ni = clamp_cnt(items_reg);
    nb = clamp_cnt(bidders_reg);
    foreach (price[i]) price[i] = 0;
    foreach (owner[b]) owner[b] = -1;
    for (int b = 0; b < nb; b++) waiting = {waiting, b};
    rounds = 0;
    while (waiting.size() > 0 && rounds < iter_reg) begin
      who = waiting[0];
      waiting.delete(0);
      best = 0;
      second = 0;
      best_i = 0;
      have_second = 0;
      for (int i = 0; i < ni; i++) begin
        val = cost_mem[i][who] - price[i];
        if (i == 0) begin
          best = val;
        end else if (val > best) begin
          second = best;
          have_second = 1;
          best = val;
          best_i = i;
        end else if (!have_second || val > second) begin
          second = val;
          have_second = 1;
        end
      end
      for (int b = 0; b < nb; b++) begin
        if (owner[b] == best_i) begin
          owner[b] = -1;
          waiting = {waiting, b};
          break;
        end
      end
      owner[who] = best_i;
      inc = eps_reg;
      if (have_second) inc += best - second;
      np = price[best_i] + inc;
      if (np > PriceMax || np < price[best_i]) np = PriceMax;
      price[best_i] = np;
      rounds++;
    end
    for (int b = 0; b < nb; b++) begin
      beat.bidder = 4'(b);
      beat.item = 5'(owner[b]);
      beat.early = waiting.size() > 0;
      beat.last = (b + 1 == nb);
      expected_assign = {expected_assign, beat};
    end
  endfunction

  task automatic send_item(logic op, logic [3:0] it, logic [3:0] bd, logic [31:0] cost);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    item_index <= it;
    bidder_index <= bd;
    cost_value <= cost;
    do @(posedge clk); while (in_stall);
    if (op == OpLoad) begin
      cost_mem[it][bd] = longint'($signed(cost));
      loaded[it][bd] = 1;
    end else begin
      predict_assignment();
    end
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_cost();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom;
      default: return $urandom_range(32'h0006_0000) - 32'h0003_0000;
    endcase
  endfunction

  task automatic load_cost(int it, int bd);
    send_item(OpLoad, 4'(it), 4'(bd), pick_cost());
  endtask

  // fill every entry the next solve will use
  task automatic solve_now();
    for (int i = 0; i < clamp_cnt(items_reg); i++)
      for (int b = 0; b < clamp_cnt(bidders_reg); b++)
        if (!loaded[i][b]) load_cost(i, b);
    send_item(OpSolve, 4'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (expected_assign.size() == 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegBidInc:  eps_reg = data[20:0];
      RegMaxIter: iter_reg = data[19:0];
      RegItems:   items_reg = data[4:0];
      default:    bidders_reg = data[4:0];
    endcase
    @(negedge clk);
  endtask

  task automatic setup(int eps, int iters, int ni, int nb);
    wait_idle();
    write_reg(RegBidInc, eps);
    write_reg(RegMaxIter, iters);
    write_reg(RegItems, ni);
    write_reg(RegBidders, nb);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    // exercise reset values on a small region is impossible at 16x16 cheaply;
    // instead shrink only the size registers
    wait_idle();
    write_reg(RegItems, 2);
    write_reg(RegBidders, 2);
    cfg_valid <= 1'b0;
    solve_now();
  endtask

  task automatic test_field_extremes();
    setup(66, 1000, 2, 2);
    send_item(OpLoad, 0, 0, 32'h7fff_ffff);
    send_item(OpLoad, 1, 0, 32'h8000_0000);
    send_item(OpLoad, 0, 1, 32'h7fff_ffff);
    send_item(OpLoad, 1, 1, 32'h7fff_ffff);
    send_item(OpLoad, 15, 15, 32'h1234_5678);
    solve_now();
  endtask

  task automatic test_single_item_many_bidders();
    setup(1048576, 40, 1, 16);
    solve_now();
  endtask

  task automatic test_many_items_single_bidder();
    setup(1, 1048575, 16, 1);
    solve_now();
  endtask

  task automatic test_more_bidders_than_items();
    setup(5000, 60, 2, 5);
    solve_now();
  endtask

  task automatic test_zero_limit_and_increment();
    setup(0, 0, 3, 3);
    solve_now();
    setup(0, 200, 3, 3);
    for (int b = 0; b < 3; b++) send_item(OpLoad, 0, 4'(b), 32'h0001_0000);
    solve_now();
  endtask

  task automatic test_count_clamps();
    setup(32'hffff_ffff, 32'hfff0_0010, 0, 0);
    solve_now();
    setup(66, 300, 31, 1);
    solve_now();
    setup(66, 300, 1, 17);
    solve_now();
  endtask

  // the receiver holds off once results show up while loads keep coming
  task automatic test_backpressure();
    setup(700, 500, 4, 4);
    hold_arm = 1'b1;
    solve_now();
    for (int k = 0; k < 6; k++) load_cost($urandom_range(3), $urandom_range(3));
    solve_now();
  endtask

  task automatic test_random_auctions(int upto);
    int ni, nb;
    while (items_sent < upto) begin
      if ($urandom_range(9) == 0) begin
        ni = $urandom_range(16, 1);
        nb = $urandom_range(4, 1);
      end else begin
        ni = $urandom_range(6, 1);
        nb = $urandom_range(6, 1);
      end
      setup($urandom_range(1048576), $urandom_range(9) == 0 ? $urandom_range(8, 1)
            : $urandom_range(300, 20), ni, nb);
      repeat ($urandom_range(8)) load_cost($urandom_range(15), $urandom_range(15));
      solve_now();
      if ($urandom_range(3) == 0) begin
        for (int b = 0; b < nb; b++) load_cost($urandom_range(ni - 1), b);
        solve_now();
      end
    end
  endtask

  // receiver side: random stall, or a long hold-off when armed
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (hold_arm && out_valid) begin
      out_stall <= 1'b1;
      hold_off <= 400;
      hold_arm <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    assign_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_assign.size() == 0) begin
        $error("result beat with none expected: bidder %0d", bidder);
        errors++;
      end else begin
        want = expected_assign[0];
        expected_assign.delete(0);
        if (bidder !== want.bidder) begin
          $error("bidder: expected %0d, got %0d", want.bidder, bidder);
          errors++;
        end
        if (assigned_item !== want.item) begin
          $error("assigned_item: expected %0d, got %0d", $signed(want.item), assigned_item);
          errors++;
        end
        if (stopped_early !== want.early) begin
          $error("stopped_early: expected %0b, got %0b", want.early, stopped_early);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OpLoad;
    item_index = '0;
    bidder_index = '0;
    cost_value = '0;
    cfg_valid = 1'b0;
    cfg_index = RegBidInc;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    hold_off = 0;
    hold_arm = 1'b0;
    send_idle_pct = 12;
    recv_stall_pct = 81;
    eps_reg = 66;
    iter_reg = 1000;
    items_reg = 16;
    bidders_reg = 16;
    foreach (loaded[i, b]) loaded[i][b] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_single_item_many_bidders();
    test_many_items_single_bidder();
    test_more_bidders_than_items();
    test_zero_limit_and_increment();
    test_count_clamps();
    test_backpressure();
    test_random_auctions(110);
    wait_idle();
    send_idle_pct = 81;
    recv_stall_pct = 12;
    test_random_auctions(170);
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_auctions(230);

    in_valid <= 1'b0;
    wait (expected_assign.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

### files.f
hdl/aas_pkg.sv
hdl/aas_cell.sv
hdl/auction_assignment_solver.sv
tb/tb.sv
